// ===== rtl/hnt_pkg.sv =====
// Shared types and constants for the Harshad number test unit.
`timescale 1ns / 1ps

package hnt_pkg;

    // Width of the digit sum field; large enough for any 32-bit candidate.
    localparam int SUM_BITS       = 7;
    // Largest digit sum of any value below 2^32 (3999999999).
    localparam int MAX_DIGIT_SUM  = 84;
    // Width of one decimal digit.
    localparam int DIGIT_BITS     = 4;
    // Candidate bits consumed by one remainder step.
    localparam int MOD_RADIX_BITS = 4;
    // floor(v / 10) == (v * RECIP_MAGIC) >> RECIP_SHIFT for every v below 2^32.
    localparam logic [31:0] RECIP_MAGIC = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT    = 35;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_MOD,
        ST_FINISH
    } hnt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic digit_step;
        logic mod_init;
        logic mod_step;
        logic publish;
    } hnt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic value_zero;
        logic mod_last;
        logic out_free;
    } hnt_status_t;

endpackage

// ===== rtl/hnt_if.sv =====
// Valid/ready channel interfaces for candidates and results.
`timescale 1ns / 1ps

interface hnt_cand_if #(
    parameter int NUMBER_BITS = 31
);
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] number;
    logic                   last_candidate;

    modport source (output valid, output number, output last_candidate, input ready);
    modport sink   (input valid, input number, input last_candidate, output ready);
endinterface

interface hnt_res_if
    import hnt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                is_harshad;
    logic [SUM_BITS-1:0] digit_sum;
    logic                last_result;

    modport source (output valid, output is_harshad, output digit_sum, output last_result,
                    input ready);
    modport sink   (input valid, input is_harshad, input digit_sum, input last_result,
                    output ready);
endinterface

// ===== rtl/harshad_number_test_unit.sv =====
// Top level of the Harshad number test unit.
`timescale 1ns / 1ps

// Harshad number test unit.
// The cand channel carries one transaction per candidate: number and a
// last_candidate marker. The res channel returns one transaction per
// candidate: is_harshad, the decimal digit sum, and the marker copied.
// Zero yields digit sum 0 and is_harshad 0.
// A candidate is loaded at the accepting edge, then goes through the digit
// loop (a reciprocal multiply by one tenth per cycle, one step per decimal
// digit), then ceil(NUMBER_BITS/4) remainder steps, then the write of the
// output register. A new candidate is accepted in the cycle the previous
// result is written.
// The output register holds a finished result while the receiver stalls;
// the next candidate is already worked on and waits only at write-back.
// Reset clears the controller and the output valid; no result is pending
// afterwards and the block is ready for a candidate at once.
module harshad_number_test_unit
    import hnt_pkg::*;
#(
    parameter int NUMBER_BITS = 31
) (
    input logic       clk,
    input logic       rst_n,
    hnt_cand_if.sink  cand,
    hnt_res_if.source res
);

    hnt_cmd_t    cmd;
    hnt_status_t status;
    logic        in_ready;

    hnt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cand.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hnt_datapath #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .number         (cand.number),
        .last_candidate (cand.last_candidate),
        .cmd            (cmd),
        .status         (status),
        .res            (res)
    );

    assign cand.ready = in_ready;

    // A result is never written over one that the receiver has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!res.valid || res.ready))
        else $error("result written into a full output register");

    // The datapath phases never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.digit_step, cmd.mod_init, cmd.mod_step}))
        else $error("conflicting datapath commands");

    // A Harshad verdict requires a nonzero digit sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.is_harshad) |-> (res.digit_sum != '0))
        else $error("Harshad result with zero digit sum");

    // The digit sum never exceeds that of any 32-bit value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.digit_sum <= SUM_BITS'(MAX_DIGIT_SUM)))
        else $error("digit sum out of range");

endmodule

// ===== rtl/hnt_datapath.sv =====
// Datapath: digit extraction by reciprocal multiply, radix-16 remainder, output register.
`timescale 1ns / 1ps

module hnt_datapath
    import hnt_pkg::*;
#(
    parameter int NUMBER_BITS = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [NUMBER_BITS-1:0] number,
    input  logic                   last_candidate,
    input  hnt_cmd_t               cmd,
    output hnt_status_t            status,
    hnt_res_if.source              res
);

    localparam int MOD_STEPS = (NUMBER_BITS + MOD_RADIX_BITS - 1) / MOD_RADIX_BITS;
    localparam int PAD_BITS  = MOD_STEPS * MOD_RADIX_BITS;
    localparam int CNT_BITS  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam int PROD_BITS = NUMBER_BITS + RECIP_SHIFT;

    logic [PAD_BITS-1:0]    num_reg,  num_next;
    logic [NUMBER_BITS-1:0] val_reg,  val_next;
    logic [SUM_BITS-1:0]    sum_reg,  sum_next;
    logic [SUM_BITS-1:0]    rem_reg,  rem_next;
    logic [CNT_BITS-1:0]    cnt_reg,  cnt_next;
    logic                   last_reg;

    logic                   out_valid_reg;
    logic                   out_harshad_reg;
    logic [SUM_BITS-1:0]    out_sum_reg;
    logic                   out_last_reg;

    logic [PROD_BITS-1:0]   prod;
    logic [NUMBER_BITS-1:0] quot;
    logic [NUMBER_BITS-1:0] digit_wide;
    logic [DIGIT_BITS-1:0]  digit;
    logic [SUM_BITS-1:0]    rem_step;

    // Divide by ten through the reciprocal; the remainder is the low digit.
    always_comb
    begin
        prod       = PROD_BITS'(val_reg) * PROD_BITS'(RECIP_MAGIC);
        quot       = prod[RECIP_SHIFT +: NUMBER_BITS];
        digit_wide = val_reg - ((quot << 3) + (quot << 1));
        digit      = digit_wide[DIGIT_BITS-1:0];
    end

    // Four restoring remainder steps, one candidate bit each, MSB first.
    always_comb
    begin
        logic [SUM_BITS:0]   trial;
        logic [SUM_BITS-1:0] r;
        r = rem_reg;
        for (int k = 0; k < MOD_RADIX_BITS; k++)
        begin
            trial = {r, num_reg[PAD_BITS-1-k]};
            if (trial >= {1'b0, sum_reg})
            begin
                trial = trial - {1'b0, sum_reg};
            end
            r = trial[SUM_BITS-1:0];
        end
        rem_step = r;
    end

    always_comb
    begin
        num_next = num_reg;
        val_next = val_reg;
        sum_next = sum_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            num_next = PAD_BITS'(number);
            val_next = number;
            sum_next = '0;
        end
        else if (cmd.digit_step)
        begin
            val_next = quot;
            sum_next = sum_reg + SUM_BITS'(digit);
        end
        else if (cmd.mod_init)
        begin
            rem_next = '0;
            cnt_next = CNT_BITS'(MOD_STEPS - 1);
        end
        else if (cmd.mod_step)
        begin
            rem_next = rem_step;
            num_next = num_reg << MOD_RADIX_BITS;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        val_reg <= val_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (cmd.load)
        begin
            last_reg <= last_candidate;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_harshad_reg <= (sum_reg != '0) && (rem_reg == '0);
            out_sum_reg     <= sum_reg;
            out_last_reg    <= last_reg;
        end
    end

    assign status.value_zero = (val_reg == '0);
    assign status.mod_last   = (cnt_reg == '0);
    assign status.out_free   = !out_valid_reg || res.ready;

    assign res.valid       = out_valid_reg;
    assign res.is_harshad  = out_harshad_reg;
    assign res.digit_sum   = out_sum_reg;
    assign res.last_result = out_last_reg;

endmodule

// ===== rtl/hnt_ctrl.sv =====
// Controller state machine sequencing digit extraction, remainder and result hand-off.
`timescale 1ns / 1ps

module hnt_ctrl
    import hnt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hnt_status_t status,
    output hnt_cmd_t    cmd
);

    hnt_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (status.value_zero)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (status.mod_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = in_valid ? ST_DIGITS : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIGITS:
            begin
                cmd.digit_step = !status.value_zero;
                cmd.mod_init   = status.value_zero;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            ST_FINISH:
            begin
                // The result leaves and the next candidate enters in the same cycle.
                in_ready    = status.out_free;
                cmd.publish = status.out_free;
                cmd.load    = status.out_free && in_valid;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
